// ===== sv/bra_pkg.sv =====
// shared types and constants for the bitmap run allocator
`timescale 1ns / 1ps
package bra_pkg;

	localparam int NUM_BITS_DEF = 4096;
	localparam int BYTE_W       = 8;
	localparam int OP_W         = 3;
	localparam int IDX_W        = 12;
	localparam int RUN_W        = 13;
	localparam int CFG_W        = 10;
	localparam logic [CFG_W-1:0] BYTES_RST = 10'd512;
	localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

	typedef enum logic [OP_W-1:0] {
		OP_TEST    = 3'd0,
		OP_SET     = 3'd1,
		OP_CLEAR   = 3'd2,
		OP_SCAN    = 3'd3,
		OP_CLR_ALL = 3'd4
	} op_t;

	// outcome of walking one byte of the bitmap
	typedef struct packed {
		logic             hit;
		logic [2:0]       pos;
		logic [RUN_W-1:0] run;
	} scan_res_t;

endpackage

// ===== sv/bra_if.sv =====
// command and response channel interfaces
`timescale 1ns / 1ps
interface bra_cmd_if;
	logic                     valid;
	logic                     ready;
	logic [bra_pkg::OP_W-1:0]  opcode;
	logic [bra_pkg::IDX_W-1:0] bit_index;
	logic [bra_pkg::RUN_W-1:0] run_length;

	modport source (output valid, output opcode, output bit_index, output run_length,
		input ready);
	modport sink (input valid, input opcode, input bit_index, input run_length,
		output ready);
endinterface

interface bra_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      bit_value;
	logic                      found;
	logic [bra_pkg::IDX_W-1:0] start_index;

	modport source (output valid, output bit_value, output found, output start_index,
		input ready);
	modport sink (input valid, input bit_value, input found, input start_index,
		output ready);
endinterface

// ===== sv/bitmap_run_allocator.sv =====
// bitmap allocator with bit test/set/clear, clear-all and first-fit run scan
//
//  channel  dir  beat fields
//  cmd      in   opcode, bit_index, run_length
//  rsp      out  bit_value, found, start_index
//  cfg      in   cfg_we, cfg_wdata (bytes_in_use)
//
// test, set and clear pass S_MOD and S_PUSH before rsp valid, unknown codes S_PUSH only;
// clear-all sweeps the store in S_CLEAR, one byte written per cycle.
// a scan reads one byte per cycle from the single-port store, up to min(bytes_in_use,
// (NUM_BITS+7)/8) bytes, fewer when a run is found early.
// after reset all (NUM_BITS+7)/8 bytes of the store are swept to zero; cmd is not ready.
// one command at a time; a new command is taken while a response beat waits.
`timescale 1ns / 1ps
module bitmap_run_allocator #(
	parameter int NUM_BITS = bra_pkg::NUM_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bra_pkg::CFG_W-1:0] cfg_wdata,
	bra_cmd_if.sink                   cmd,
	bra_rsp_if.source                 rsp
);
	import bra_pkg::*;

	localparam int SB = (NUM_BITS + 7) / 8;
	localparam int AW = (SB > 1) ? $clog2(SB) : 1;
	localparam int LW = $clog2(SB + 1);
	localparam int PW = AW + 3;
	localparam int XW = (PW > RUN_W) ? PW : RUN_W;
	localparam int TAIL = NUM_BITS % 8;
	localparam logic [BYTE_W-1:0] LAST_MASK =
		(TAIL == 0) ? FULL_BYTE : BYTE_W'((1 << TAIL) - 1);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_MOD   = 6'b000100,
		S_SCAN  = 6'b001000,
		S_PUSH  = 6'b010000,
		S_SPARE = 6'b100000
	} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   cfg_q;
	logic [LW-1:0]      ptr_q;
	logic               clr_rsp_q;
	op_t                op_q;
	logic [IDX_W-1:0]   idx_q;
	logic [RUN_W-1:0]   want_q;
	logic [RUN_W-1:0]   run_q;
	logic               v_s1;
	logic [AW-1:0]      b_s1;
	logic               hit_q;
	logic [PW-1:0]      end_q;
	logic               bit_q;
	logic               rsp_v_q;
	logic               rsp_bit_q;
	logic               rsp_fnd_q;
	logic [IDX_W-1:0]   rsp_start_q;

	logic [BYTE_W-1:0]  mem [SB];
	logic [BYTE_W-1:0]  mem_rd;
	logic               mem_re;
	logic [AW-1:0]      mem_ra;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [BYTE_W-1:0]  mem_wd;

	logic [LW-1:0]      len_eff;
	logic               issue;
	logic               idx_ok;
	logic               cmd_take;
	logic               push_ok;
	logic [BYTE_W-1:0]  byte_mask;
	logic [XW-1:0]      start_full;
	scan_res_t          sr;

	assign len_eff   = (int'(cfg_q) > SB) ? LW'(SB) : LW'(cfg_q);
	assign issue     = (state_q == S_SCAN) && (ptr_q < len_eff);
	assign idx_ok    = 32'(idx_q) < NUM_BITS;
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_take  = cmd.valid && cmd.ready;
	assign push_ok   = !rsp_v_q || rsp.ready;
	assign byte_mask = (32'(b_s1) == SB - 1) ? LAST_MASK : FULL_BYTE;
	assign start_full = XW'(end_q) + 1'b1 - XW'(want_q);

	bra_byte_scan u_byte_scan (
		.data   (mem_rd),
		.mask   (byte_mask),
		.run_in (run_q),
		.want   (want_q),
		.res    (sr)
	);

	// store port control
	always_comb begin
		mem_re = 1'b0;
		mem_ra = ptr_q[AW-1:0];
		mem_we = 1'b0;
		mem_wa = idx_q[IDX_W-1:3] == '0 ? '0 : AW'(idx_q >> 3);
		mem_wd = mem_rd;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = ptr_q[AW-1:0];
				mem_wd = '0;
			end
			S_IDLE: begin
				mem_re = cmd_take;
				mem_ra = AW'(cmd.bit_index >> 3);
			end
			S_MOD: begin
				mem_wa = AW'(idx_q >> 3);
				if (op_q == OP_SET) begin
					mem_we = idx_ok;
					mem_wd = mem_rd | (BYTE_W'(1) << idx_q[2:0]);
				end else if (op_q == OP_CLEAR) begin
					mem_we = idx_ok;
					mem_wd = mem_rd & ~(BYTE_W'(1) << idx_q[2:0]);
				end
			end
			S_SCAN: begin
				mem_re = issue;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			mem_rd <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= BYTES_RST;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			ptr_q     <= '0;
			clr_rsp_q <= 1'b0;
			v_s1      <= 1'b0;
			hit_q     <= 1'b0;
			bit_q     <= 1'b0;
		end else begin
			v_s1 <= issue;
			unique case (state_q)
				S_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == LW'(SB - 1))
						state_q <= clr_rsp_q ? S_PUSH : S_IDLE;
				end
				S_IDLE: begin
					if (cmd_take) begin
						ptr_q     <= '0;
						hit_q     <= 1'b0;
						bit_q     <= 1'b0;
						clr_rsp_q <= 1'b0;
						unique case (op_t'(cmd.opcode))
							OP_TEST, OP_SET, OP_CLEAR: state_q <= S_MOD;
							OP_SCAN: begin
								if (cmd.run_length == '0 || len_eff == '0)
									state_q <= S_PUSH;
								else
									state_q <= S_SCAN;
							end
							OP_CLR_ALL: begin
								clr_rsp_q <= 1'b1;
								state_q   <= S_CLEAR;
							end
							default: state_q <= S_PUSH;
						endcase
					end
				end
				S_MOD: begin
					if (op_q == OP_TEST)
						bit_q <= idx_ok & mem_rd[idx_q[2:0]];
					state_q <= S_PUSH;
				end
				S_SCAN: begin
					if (issue)
						ptr_q <= ptr_q + 1'b1;
					if (v_s1 && sr.hit) begin
						hit_q   <= 1'b1;
						state_q <= S_PUSH;
					end else if (!v_s1 && !issue) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (push_ok)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command and scan payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			op_q   <= op_t'(cmd.opcode);
			idx_q  <= cmd.bit_index;
			want_q <= cmd.run_length;
			run_q  <= '0;
		end
		b_s1 <= ptr_q[AW-1:0];
		if (state_q == S_SCAN && v_s1) begin
			run_q <= sr.run;
			end_q <= {b_s1, sr.pos};
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (state_q == S_PUSH && push_ok) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PUSH && push_ok) begin
			rsp_bit_q   <= bit_q;
			rsp_fnd_q   <= hit_q;
			rsp_start_q <= hit_q ? IDX_W'(start_full) : '0;
		end
	end

	assign rsp.valid       = rsp_v_q;
	assign rsp.bit_value   = rsp_bit_q;
	assign rsp.found       = rsp_fnd_q;
	assign rsp.start_index = rsp_start_q;

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !mem_we)
		else $error("store written during a scan");

	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_re && mem_we))
		else $error("store read and written in the same cycle");

	a_hit_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && v_s1 && sr.hit) |=> (state_q == S_PUSH && hit_q))
		else $error("found run did not end the scan");
`endif

endmodule

// ===== sv/bra_byte_scan.sv =====
// run counting over the eight bits of one bitmap byte, lsb first
`timescale 1ns / 1ps
module bra_byte_scan (
	input  logic [bra_pkg::BYTE_W-1:0] data,
	input  logic [bra_pkg::BYTE_W-1:0] mask,
	input  logic [bra_pkg::RUN_W-1:0]  run_in,
	input  logic [bra_pkg::RUN_W-1:0]  want,
	output bra_pkg::scan_res_t         res
);
	import bra_pkg::*;

	always_comb begin
		logic [RUN_W-1:0] r;
		logic             h;
		logic [2:0]       p;
		r = run_in;
		h = 1'b0;
		p = 3'd0;
		for (int k = 0; k < BYTE_W; k++) begin
			// bits past the end of the store are skipped
			if (mask[k]) begin
				if (data[k])
					r = '0;
				else
					r = r + 1'b1;
				if (!h && r == want) begin
					h = 1'b1;
					p = 3'(k);
				end
			end
		end
		res.hit = h;
		res.pos = p;
		res.run = r;
	end

endmodule
